/* hdl/pqfd_pkg.sv */
// ----------------------------------------------------------------------------
// pqfd_pkg : shared types and constants of the pairwise distance engine
// Item payload structs, action codes and fixed-point widths.
// ----------------------------------------------------------------------------
package pqfd_pkg;

    localparam int unsigned CfgWidth  = 4;
    localparam int unsigned CfgIdxW   = 1;
    localparam logic [CfgIdxW-1:0] CfgLocations = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgDims      = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD_LOC   = 2'd0,
        ACT_LOAD_INNER = 2'd1,
        ACT_LOAD_SCALE = 2'd2,
        ACT_COMPUTE    = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         row_index;
        logic [1:0]         col_index;
        logic signed [15:0] value_re;
        logic signed [15:0] value_im;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         first_location;
        logic [2:0]         second_location;
        logic signed [47:0] dist_re;
        logic signed [47:0] dist_im;
        logic               last_pair;
    } t_out_item;

    // multiply-accumulate unit operands and control
    // a carries scales, v or w (w needs 24 bits); b carries differences,
    // table entries or v (v needs 20 bits)
    typedef struct packed {
        logic signed [23:0] a_re;
        logic signed [23:0] a_im;
        logic signed [19:0] b_re;
        logic signed [19:0] b_im;
        logic               clear;
    } t_mac_op;

endpackage

/* hdl/pairwise_quadratic_form_distance.sv */
// ----------------------------------------------------------------------------
// pairwise_quadratic_form_distance : pairwise bilinear-form distance engine
// Loads location vectors, inner-product table and scales; computes v^T M v.
// ----------------------------------------------------------------------------
// Usage: drive i_item and raise start; an item is taken at the edge where
// start is high and busy is low. Load actions write one complex entry at that
// edge and finish there (busy stays low), so loads can follow back to back.
// A compute item raises busy and emits one result per pair i<j, i outer,
// j inner, each on o_item for one cycle with o_valid; the final one has
// last_pair set. The receiver cannot stall: results are simply presented.
// One shared complex MAC does everything. Per pair: d scale products, each
// followed by a drain (S_SDRAIN); per column m, d products for w, a drain,
// one form product and another drain; then one emit state. A result is
// presented as each pair completes; no item is taken while busy, and the
// next item can be taken at the edge that ends the strobe of the last result.
// Config (i_cfg_we/idx/data) is taken at any edge; use it only while idle.
// Reset (synchronous, i_rst_n low) sets 8 locations, 4 dims, idle state.
// Tables are undefined until written.
// ----------------------------------------------------------------------------
module pairwise_quadratic_form_distance #(
    parameter int unsigned MAX_LOCATIONS = 8,
    parameter int unsigned MAX_DIMS      = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  pqfd_pkg::t_in_item                 i_item,
    output logic                               o_valid,
    output pqfd_pkg::t_out_item                o_item,
    input  logic                               i_cfg_we,
    input  logic [pqfd_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [pqfd_pkg::CfgWidth-1:0]      i_cfg_data
);
    localparam int unsigned LW = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;
    localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int unsigned CW = DW + 1;  // counts up to MAX_DIMS
    localparam int unsigned LAW = $clog2(MAX_LOCATIONS*MAX_DIMS);
    localparam int unsigned MAW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS*MAX_DIMS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCALE, S_SDRAIN, S_WMAC, S_WDRAIN, S_FORM, S_FDRAIN, S_EMIT
    } t_state;

    logic signed [15:0] r_loc_re [MAX_LOCATIONS*MAX_DIMS];
    logic signed [15:0] r_loc_im [MAX_LOCATIONS*MAX_DIMS];
    logic signed [15:0] r_mt_re  [MAX_DIMS*MAX_DIMS];
    logic signed [15:0] r_mt_im  [MAX_DIMS*MAX_DIMS];
    logic signed [15:0] r_sc_re  [MAX_DIMS];
    logic signed [15:0] r_sc_im  [MAX_DIMS];
    logic signed [19:0] r_v_re   [MAX_DIMS];
    logic signed [19:0] r_v_im   [MAX_DIMS];
    logic signed [23:0] r_w_re, r_w_im;
    logic signed [63:0] r_f_re, r_f_im;   // form sum over the columns

    t_state          r_state;
    logic [3:0]      r_nloc;
    logic [2:0]      r_ndim;
    logic [LW:0]     r_n;
    logic [CW-1:0]   r_d;
    logic [LW-1:0]   r_i, r_j;
    logic [DW-1:0]   r_k, r_m;
    logic [1:0]      r_drain;
    logic            r_busy, r_valid;
    pqfd_pkg::t_out_item r_out;

    pqfd_pkg::t_mac_op s_op;
    logic              s_en;
    logic signed [63:0] s_acc_re, s_acc_im;

    pqfd_cmac u_cmac (
        .i_clk   (i_clk),
        .i_en    (s_en),
        .i_op    (s_op),
        .o_acc_re(s_acc_re),
        .o_acc_im(s_acc_im)
    );

    // round Q.28 to Q.14, half up (floor after adding half)
    function automatic logic signed [23:0] rnd14(input logic signed [63:0] x);
        logic signed [63:0] y;
        begin
            y = (x + 64'sd8192) >>> 14;
            rnd14 = 24'(y);
        end
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
        begin
            if (x > 64'sh00007FFFFFFFFFFF)
                sat48 = 48'sh7FFFFFFFFFFF;
            else if (x < -64'sh0000800000000000)
                sat48 = 48'sh800000000000;
            else
                sat48 = 48'(x);
        end
    endfunction

    // saturated register values
    logic [LW:0]   s_nsat;
    logic [CW-1:0] s_dsat;
    always_comb begin
        if (r_nloc < 4'd2)
            s_nsat = (LW+1)'(2);
        else if (32'(r_nloc) > MAX_LOCATIONS)
            s_nsat = (LW+1)'(MAX_LOCATIONS);
        else
            s_nsat = (LW+1)'(r_nloc);
        if (r_ndim < 3'd1)
            s_dsat = CW'(1);
        else if (32'(r_ndim) > MAX_DIMS)
            s_dsat = CW'(MAX_DIMS);
        else
            s_dsat = CW'(r_ndim);
    end

    // table addresses
    logic [LAW-1:0] s_loc_ai, s_loc_aj, s_loc_wa;
    logic [MAW-1:0] s_mt_ra, s_mt_wa;
    assign s_loc_ai = LAW'(32'(r_i)*MAX_DIMS + 32'(r_k));
    assign s_loc_aj = LAW'(32'(r_j)*MAX_DIMS + 32'(r_k));
    assign s_loc_wa = LAW'(32'(i_item.row_index)*MAX_DIMS + 32'(i_item.col_index));
    assign s_mt_ra  = MAW'(32'(r_k)*MAX_DIMS + 32'(r_m));
    assign s_mt_wa  = MAW'(32'(i_item.row_index)*MAX_DIMS + 32'(i_item.col_index));

    // MAC operand selection
    always_comb begin
        s_op = '0;
        s_en = 1'b0;
        case (r_state)
            S_SCALE: begin
                s_en    = 1'b1;
                s_op.a_re = 24'(r_sc_re[r_k]);
                s_op.a_im = 24'(r_sc_im[r_k]);
                s_op.b_re = 20'(r_loc_re[s_loc_ai]) - 20'(r_loc_re[s_loc_aj]);
                s_op.b_im = 20'(r_loc_im[s_loc_ai]) - 20'(r_loc_im[s_loc_aj]);
                s_op.clear = 1'b1;
            end
            S_WMAC: begin
                s_en    = 1'b1;
                s_op.a_re = 24'(r_v_re[r_k]);
                s_op.a_im = 24'(r_v_im[r_k]);
                s_op.b_re = 20'(r_mt_re[s_mt_ra]);
                s_op.b_im = 20'(r_mt_im[s_mt_ra]);
                s_op.clear = (r_k == '0);
            end
            S_FORM: begin
                // one product per column; the sum is kept in r_f
                s_en    = 1'b1;
                s_op.a_re = r_w_re;
                s_op.a_im = r_w_im;
                s_op.b_re = r_v_re[r_m];
                s_op.b_im = r_v_im[r_m];
                s_op.clear = 1'b1;
            end
            default: ;
        endcase
    end

    logic s_k_last, s_m_last, s_j_end, s_i_end;
    assign s_k_last = (CW'(r_k) == r_d - CW'(1));
    assign s_m_last = (CW'(r_m) == r_d - CW'(1));
    assign s_j_end  = ((LW+1)'(r_j) == r_n - (LW+1)'(1));
    assign s_i_end  = ((LW+1)'(r_i) == r_n - (LW+1)'(2));

    // table loads
    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            case (i_item.action)
                pqfd_pkg::ACT_LOAD_LOC: begin
                    if (32'(i_item.row_index) < MAX_LOCATIONS &&
                        32'(i_item.col_index) < MAX_DIMS) begin
                        r_loc_re[s_loc_wa] <= i_item.value_re;
                        r_loc_im[s_loc_wa] <= i_item.value_im;
                    end
                end
                pqfd_pkg::ACT_LOAD_INNER: begin
                    if (32'(i_item.row_index) < MAX_DIMS &&
                        32'(i_item.col_index) < MAX_DIMS) begin
                        r_mt_re[s_mt_wa] <= i_item.value_re;
                        r_mt_im[s_mt_wa] <= i_item.value_im;
                    end
                end
                pqfd_pkg::ACT_LOAD_SCALE: begin
                    if (32'(i_item.col_index) < MAX_DIMS) begin
                        r_sc_re[DW'(i_item.col_index)] <= i_item.value_re;
                        r_sc_im[DW'(i_item.col_index)] <= i_item.value_im;
                    end
                end
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_nloc  <= 4'd8;
            r_ndim  <= 3'd4;
        end else begin
            r_valid <= (r_state == S_EMIT);
            if (i_cfg_we) begin
                if (i_cfg_idx == pqfd_pkg::CfgLocations)
                    r_nloc <= i_cfg_data;
                else if (i_cfg_idx == pqfd_pkg::CfgDims)
                    r_ndim <= i_cfg_data[2:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (start && i_item.action == pqfd_pkg::ACT_COMPUTE) begin
                        r_busy  <= 1'b1;
                        r_n     <= s_nsat;
                        r_d     <= s_dsat;
                        r_i     <= '0;
                        r_j     <= LW'(1);
                        r_k     <= '0;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_drain <= 2'd0;
                    r_state <= S_SDRAIN;
                end
                S_SDRAIN: begin
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd1) begin
                        r_v_re[r_k] <= 20'(rnd14(s_acc_re));
                        r_v_im[r_k] <= 20'(rnd14(s_acc_im));
                        if (s_k_last) begin
                            r_k     <= '0;
                            r_m     <= '0;
                            r_state <= S_WMAC;
                        end else begin
                            r_k     <= r_k + DW'(1);
                            r_state <= S_SCALE;
                        end
                    end
                end
                S_WMAC: begin
                    if (s_k_last) begin
                        r_drain <= 2'd0;
                        r_state <= S_WDRAIN;
                    end else begin
                        r_k <= r_k + DW'(1);
                    end
                end
                S_WDRAIN: begin
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd1) begin
                        r_w_re  <= rnd14(s_acc_re);
                        r_w_im  <= rnd14(s_acc_im);
                        r_state <= S_FORM;
                    end
                end
                S_FORM: begin
                    r_drain <= 2'd0;
                    r_state <= S_FDRAIN;
                end
                S_FDRAIN: begin
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd1) begin
                        r_f_re <= (r_m == '0) ? s_acc_re : r_f_re + s_acc_re;
                        r_f_im <= (r_m == '0) ? s_acc_im : r_f_im + s_acc_im;
                        if (s_m_last) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_m     <= r_m + DW'(1);
                            r_k     <= '0;
                            r_state <= S_WMAC;
                        end
                    end
                end
                S_EMIT: begin
                    r_out.first_location  <= 3'(r_i);
                    r_out.second_location <= 3'(r_j);
                    r_out.dist_re         <= sat48(r_f_re);
                    r_out.dist_im         <= sat48(r_f_im);
                    r_k                   <= '0;
                    r_out.last_pair       <= s_j_end && s_i_end;
                    if (s_j_end) begin
                        if (s_i_end) begin
                            r_busy          <= 1'b0;
                            r_state         <= S_IDLE;
                        end else begin
                            r_i     <= r_i + LW'(1);
                            r_j     <= r_i + LW'(2);
                            r_state <= S_SCALE;
                        end
                    end else begin
                        r_j     <= r_j + LW'(1);
                        r_state <= S_SCALE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_valid;
    assign o_item  = r_out;
endmodule

/* hdl/pqfd_cmac.sv */
// ----------------------------------------------------------------------------
// pqfd_cmac : shared complex multiply-accumulate unit
// One 24x20 complex product per cycle, registered, then accumulated in 64 bits where i_en was high.
// ----------------------------------------------------------------------------
module pqfd_cmac (
    input  logic               i_clk,
    input  logic               i_en,
    input  pqfd_pkg::t_mac_op  i_op,
    output logic signed [63:0] o_acc_re,
    output logic signed [63:0] o_acc_im
);
    logic signed [43:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic               r_clr, r_vld;
    logic signed [63:0] r_acc_re, r_acc_im;
    logic signed [63:0] n_base_re, n_base_im;

    always_ff @(posedge i_clk) begin
        r_p_rr <= 44'(i_op.a_re * i_op.b_re);
        r_p_ii <= 44'(i_op.a_im * i_op.b_im);
        r_p_ri <= 44'(i_op.a_re * i_op.b_im);
        r_p_ir <= 44'(i_op.a_im * i_op.b_re);
        r_clr  <= i_op.clear;
        r_vld  <= i_en;
    end

    always_comb begin
        n_base_re = r_clr ? 64'sd0 : r_acc_re;
        n_base_im = r_clr ? 64'sd0 : r_acc_im;
    end

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_acc_re <= n_base_re + 64'(r_p_rr) - 64'(r_p_ii);
            r_acc_im <= n_base_im + 64'(r_p_ri) + 64'(r_p_ir);
        end
    end

    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;
endmodule

/* tb/pairwise_quadratic_form_distance_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pairwise_quadratic_form_distance_tb : self-checking bench for the engine
// Loads tables, issues compute items under several sizes and idling phases,
// and checks every pair result against a fixed-point predictor kept here.
// ----------------------------------------------------------------------------
module pairwise_quadratic_form_distance_tb;

    localparam int NLOC = 8;
    localparam int NDIM = 4;
    localparam int WATCHDOG_LIMIT = 40000;   // idle cycles
    localparam int DRAIN_CYCLES = 40;
    localparam longint SAT_HI = 64'sd140737488355327;
    localparam longint SAT_LO = -64'sd140737488355328;

    typedef struct {
        longint re;
        longint im;
    } t_cplx;

    // directed table row: item plus optional typed-in expectation
    typedef struct {
        pqfd_pkg::t_in_item  item;
        bit                  has_fixed;
        pqfd_pkg::t_out_item fixed;
    } t_directed_row;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    pqfd_pkg::t_in_item  in_item;
    logic      out_valid;
    pqfd_pkg::t_out_item out_item;
    logic      cfg_we;
    logic [pqfd_pkg::CfgIdxW-1:0]  cfg_idx;
    logic [pqfd_pkg::CfgWidth-1:0] cfg_data;

    // predictor state
    t_cplx loc_vec [NLOC][NDIM];
    t_cplx inner_tab [NDIM][NDIM];
    t_cplx scales [NDIM];
    int    n_locs;
    int    n_dims;

    pqfd_pkg::t_out_item pending_pairs[$];
    int        fail_count;
    int        idle_cycles;
    int        send_idle_pct;

    pairwise_quadratic_form_distance u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (in_item),
        .o_valid    (out_valid),
        .o_item     (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // --- fixed-point helpers ------------------------------------------------
    function automatic t_cplx cplx_mul(t_cplx a, t_cplx b);
        t_cplx r;
        r.re = a.re * b.re - a.im * b.im;
        r.im = a.re * b.im + a.im * b.re;
        return r;
    endfunction

    // Q.28 to Q.14, round half up: add half, then floor (>>> floors)
    function automatic longint round_q14(longint x);
        return (x + 64'sd8192) >>> 14;
    endfunction

    function automatic logic [47:0] saturate48(longint x);
        if (x > SAT_HI) x = SAT_HI;
        if (x < SAT_LO) x = SAT_LO;
        return x[47:0];
    endfunction

    // --- predictor: apply one accepted item, queue the pair distances -------
    task automatic predict_item(pqfd_pkg::t_in_item it);
        t_cplx val, v[NDIM], w, t, p, acc, diff;
        int total, count;
        val.re = it.value_re;
        val.im = it.value_im;
        case (pqfd_pkg::t_action'(it.action))
            pqfd_pkg::ACT_LOAD_LOC: begin
                loc_vec[it.row_index][it.col_index] = val;
            end
            pqfd_pkg::ACT_LOAD_INNER: begin
                // rows beyond the table are ignored
                if (it.row_index < NDIM) inner_tab[it.row_index][it.col_index] = val;
            end
            pqfd_pkg::ACT_LOAD_SCALE: begin
                scales[it.col_index] = val;
            end
            pqfd_pkg::ACT_COMPUTE: begin
                total = n_locs * (n_locs - 1) / 2;
                count = 0;
                for (int i = 0; i + 1 < n_locs; i++) begin
                    for (int j = i + 1; j < n_locs; j++) begin
                        pqfd_pkg::t_out_item r;
                        acc.re = 0;
                        acc.im = 0;
                        for (int k = 0; k < n_dims; k++) begin
                            diff.re = loc_vec[i][k].re - loc_vec[j][k].re;
                            diff.im = loc_vec[i][k].im - loc_vec[j][k].im;
                            p = cplx_mul(scales[k], diff);
                            v[k].re = round_q14(p.re);
                            v[k].im = round_q14(p.im);
                        end
                        for (int m = 0; m < n_dims; m++) begin
                            w.re = 0;
                            w.im = 0;
                            for (int k = 0; k < n_dims; k++) begin
                                p = cplx_mul(v[k], inner_tab[k][m]);
                                w.re += p.re;
                                w.im += p.im;
                            end
                            w.re = round_q14(w.re);
                            w.im = round_q14(w.im);
                            t = cplx_mul(w, v[m]);
                            acc.re += t.re;
                            acc.im += t.im;
                        end
                        count++;
                        r.first_location  = i[2:0];
                        r.second_location = j[2:0];
                        r.dist_re   = saturate48(acc.re);
                        r.dist_im   = saturate48(acc.im);
                        r.last_pair = (count == total);
                        pending_pairs.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // --- result checker: every strobed result against the oldest pending ----
    always @(posedge clk) begin
        if (rst_n && out_valid) begin
            if (pending_pairs.size() == 0) begin
                $error("unexpected result i=%0d j=%0d", out_item.first_location,
                       out_item.second_location);
                fail_count++;
            end else begin
                pqfd_pkg::t_out_item e;
                e = pending_pairs.pop_front();
                if (out_item.first_location !== e.first_location) begin
                    $error("first_location exp %0d got %0d", e.first_location,
                           out_item.first_location);
                    fail_count++;
                end
                if (out_item.second_location !== e.second_location) begin
                    $error("second_location exp %0d got %0d", e.second_location,
                           out_item.second_location);
                    fail_count++;
                end
                if (out_item.dist_re !== e.dist_re) begin
                    $error("dist_re exp %0d got %0d", e.dist_re, out_item.dist_re);
                    fail_count++;
                end
                if (out_item.dist_im !== e.dist_im) begin
                    $error("dist_im exp %0d got %0d", e.dist_im, out_item.dist_im);
                    fail_count++;
                end
                if (out_item.last_pair !== e.last_pair) begin
                    $error("last_pair exp %0b got %0b", e.last_pair, out_item.last_pair);
                    fail_count++;
                end
            end
        end
    end

    // --- watchdog: cycles with neither an item nor a result accepted --------
    always @(posedge clk) begin
        if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // --- drivers ------------------------------------------------------------
    // Offer one item, honour the sender idle percentage, wait for acceptance.
    // start stays high afterwards so that the next item can follow at once.
    task automatic send_item(pqfd_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_item(it);
    endtask

    // Wait for all expected results, then a short settle before a register write.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_pairs.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [pqfd_pkg::CfgIdxW-1:0] idx,
                             logic [pqfd_pkg::CfgWidth-1:0] val);
        int v;
        start    <= 1'b0;
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        v = val;
        if (idx == pqfd_pkg::CfgLocations) n_locs = (v < 2) ? 2 : (v > NLOC ? NLOC : v);
        else n_dims = (v < 1) ? 1 : (v > NDIM ? NDIM : v);
    endtask

    function automatic pqfd_pkg::t_in_item make_item(pqfd_pkg::t_action a, int row,
                                                     int col, int re, int im);
        pqfd_pkg::t_in_item it;
        it.action    = a;
        it.row_index = row[2:0];
        it.col_index = col[1:0];
        it.value_re  = re[15:0];
        it.value_im  = im[15:0];
        return it;
    endfunction

    // Fill every table entry so that no compute reads an unwritten one.
    task automatic load_all(bit extreme);
        int re, im;
        for (int k = 0; k < NDIM; k++) begin
            re = extreme ? -32768 : $urandom_range(65535);
            im = extreme ? -32768 : $urandom_range(65535);
            send_item(make_item(pqfd_pkg::ACT_LOAD_SCALE, 0, k, re, im));
            for (int m = 0; m < NDIM; m++) begin
                re = extreme ? 32767 : $urandom_range(65535);
                im = extreme ? 32767 : $urandom_range(65535);
                send_item(make_item(pqfd_pkg::ACT_LOAD_INNER, k, m, re, im));
            end
        end
        for (int l = 0; l < NLOC; l++) begin
            for (int k = 0; k < NDIM; k++) begin
                re = extreme ? ((l % 2) ? 32767 : -32768) : $urandom_range(65535);
                im = extreme ? ((l % 2) ? -32768 : 32767) : $urandom_range(65535);
                send_item(make_item(pqfd_pkg::ACT_LOAD_LOC, l, k, re, im));
            end
        end
    endtask

    function automatic pqfd_pkg::t_in_item random_item();
        pqfd_pkg::t_in_item it;
        int r;
        r = $urandom_range(99);
        it = make_item(pqfd_pkg::ACT_LOAD_LOC, $urandom_range(7), $urandom_range(3),
                       $urandom_range(65535), $urandom_range(65535));
        // compute is rare: each one brings up to 28 results
        if (r < 12) it.action = pqfd_pkg::ACT_COMPUTE;
        else if (r < 55) it.action = pqfd_pkg::ACT_LOAD_LOC;
        else if (r < 80) it.action = pqfd_pkg::ACT_LOAD_INNER;
        else it.action = pqfd_pkg::ACT_LOAD_SCALE;
        return it;
    endfunction

    // --- main sequence ------------------------------------------------------
    t_directed_row directed[$];

    initial begin
        t_directed_row row;
        pqfd_pkg::t_out_item got;
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_idx = pqfd_pkg::CfgLocations;
        cfg_data = '0;
        fail_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        n_locs = NLOC;
        n_dims = NDIM;
        foreach (loc_vec[a, b]) loc_vec[a][b] = '{0, 0};
        foreach (inner_tab[a, b]) inner_tab[a][b] = '{0, 0};
        foreach (scales[a]) scales[a] = '{0, 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all-zero tables at smallest size give a zero distance
        // with last set on the one pair; then extreme values.
        write_reg(pqfd_pkg::CfgLocations, 4'd2);
        write_reg(pqfd_pkg::CfgDims, 3'd1);
        for (int l = 0; l < 2; l++) begin
            row.item = make_item(pqfd_pkg::ACT_LOAD_LOC, l, 0, 0, 0);
            row.has_fixed = 1'b0;
            directed.push_back(row);
        end
        row.item = make_item(pqfd_pkg::ACT_LOAD_SCALE, 0, 0, 0, 0);
        directed.push_back(row);
        row.item = make_item(pqfd_pkg::ACT_LOAD_INNER, 0, 0, 0, 0);
        directed.push_back(row);
        row.item = make_item(pqfd_pkg::ACT_COMPUTE, 0, 0, 0, 0);
        row.has_fixed = 1'b1;
        row.fixed = '{3'd0, 3'd1, 48'sd0, 48'sd0, 1'b1};
        directed.push_back(row);
        // inner row beyond the table is ignored: result unchanged
        row.item = make_item(pqfd_pkg::ACT_LOAD_INNER, 7, 0, 32767, 32767);
        row.has_fixed = 1'b0;
        directed.push_back(row);
        row.item = make_item(pqfd_pkg::ACT_COMPUTE, 0, 0, 0, 0);
        row.has_fixed = 1'b1;
        directed.push_back(row);
        foreach (directed[n]) begin
            send_item(directed[n].item);
            if (directed[n].has_fixed) begin
                // typed-in value must agree with the predictor too
                got = pending_pairs[pending_pairs.size() - 1];
                if (got !== directed[n].fixed) begin
                    $error("directed row %0d: expected %p predicted %p", n,
                           directed[n].fixed, got);
                    fail_count++;
                end
            end
        end
        wait_idle();

        // extremes, largest sizes: widest intermediate values
        write_reg(pqfd_pkg::CfgLocations, 4'd15);   // clamps to the maximum
        write_reg(pqfd_pkg::CfgDims, 3'd7);
        load_all(1'b1);
        send_item(make_item(pqfd_pkg::ACT_COMPUTE, 7, 3, -1, -1));
        wait_idle();
        write_reg(pqfd_pkg::CfgLocations, 4'd0);    // clamps to two
        write_reg(pqfd_pkg::CfgDims, 3'd0);         // clamps to one
        send_item(make_item(pqfd_pkg::ACT_COMPUTE, 0, 0, 0, 0));
        wait_idle();

        // Random phases: settings change between phases, tables stay loaded.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase % 4)
                0: send_idle_pct = 0;
                1: send_idle_pct = 76;
                2: send_idle_pct = 0;
                default: send_idle_pct = 15;
            endcase
            write_reg(pqfd_pkg::CfgLocations, $urandom_range(15));
            write_reg(pqfd_pkg::CfgDims, $urandom_range(7));
            if (phase == 0) load_all(1'b0);
            for (int n = 0; n < 48; n++) begin
                send_item(random_item());
            end
            send_item(make_item(pqfd_pkg::ACT_COMPUTE, 0, 0, 0, 0));
            wait_idle();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_pairs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (pending_pairs.size() != 0)
                $error("%0d results never arrived", pending_pairs.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
